// ----- hw/rtl/fbf_pkg.sv -----
// Shared codes for the free-region allocator: command, status, policy and
// configuration register constants. No dependencies.
package fbf_pkg;

  // Command field of an input word
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fit policy register values
  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  // Configuration port geometry and register map (word index)
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic REG_FIT_POLICY = 1'b0;

endpackage

// ----- hw/rtl/fbf_ifs.sv -----
// Valid/ready channel interfaces for the allocator's input and result words.
// Depends on nothing; width follows ADDR_BITS.
interface fbf_in_if #(parameter int ADDR_BITS = 16) ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_BITS-1:0] region_start;
  logic [ADDR_BITS-1:0] req_size;

  modport source (output valid, cmd, region_start, req_size, input ready);
  modport sink   (input valid, cmd, region_start, req_size, output ready);
endinterface

interface fbf_out_if #(parameter int ADDR_BITS = 16) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] alloc_start;

  modport source (output valid, status, alloc_start, input ready);
  modport sink   (input valid, status, alloc_start, output ready);
endinterface

// ----- hw/rtl/fbf_cell.sv -----
// One slot of the free-region table plus its stage of the search chain.
// Types of the chain record and the broadcast control come from the top level.
module fbf_cell #(
  parameter int  ADDR_BITS = 16,
  parameter int  IDX_BITS  = 4,
  parameter int  IDX       = 0,
  parameter type scan_t    = logic,
  parameter type ctl_t     = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl,
  input  scan_t scan_in,
  output scan_t scan_out
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic [ADDR_BITS-1:0] start_r;
  logic [ADDR_BITS-1:0] size_r;
  logic                 valid_r;
  scan_t                scan_r;
  scan_t                scan_nxt;

  logic                 cand;
  logic                 better;
  logic                 take;
  logic [ADDR_BITS-1:0] size_left;
  logic                 hit;

  // Candidate test: empty slot for add, large enough region for allocate
  always_comb begin
    cand = ctl.alloc ? (valid_r && (size_r >= ctl.req)) : !valid_r;
    if (!ctl.alloc) begin
      better = 1'b0;
    end else if (ctl.best_fit && (size_r != scan_in.size)) begin
      better = size_r < scan_in.size;
    end else begin
      better = start_r < scan_in.start;
    end
    take = cand && (!scan_in.found || better);
  end

  // Pass the best-so-far record on, replacing it when this slot wins
  always_comb begin
    scan_nxt = scan_in;
    if (take) begin
      scan_nxt.found = 1'b1;
      scan_nxt.start = start_r;
      scan_nxt.size  = size_r;
      scan_nxt.idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.act <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

  // Slot update once the chosen index is broadcast
  assign hit       = ctl.upd && (ctl.upd_idx == MY_IDX);
  assign size_left = size_r - ctl.req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit) begin
      if (ctl.alloc) begin
        valid_r <= |size_left;
      end else begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      if (ctl.alloc) begin
        start_r <= start_r + ctl.req;
        size_r  <= size_left;
      end else begin
        start_r <= ctl.base;
        size_r  <= ctl.req;
      end
    end
  end

endmodule

// ----- hw/rtl/first_best_fit_allocator_core.sv -----
// Free-region allocator. After a word is accepted, a launch register starts
// the search record, the record walks the row of SEGMENTS table cells one
// cell per clock, the outcome is latched at the end of the row, then the
// chosen slot is written back and the result register loaded. That last
// step waits while an earlier result is still stalled.
// One word is in flight at a time. An add stores the
// region in the lowest empty slot (status full when none); an allocate
// returns the lowest-start fitting region (first fit) or the smallest one,
// ties to lowest start (best fit), per the fit_policy register at offset 0.
// Depends on fbf_pkg, fbf_ifs and fbf_cell.
module first_best_fit_allocator_core #(
  parameter int SEGMENTS  = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fbf_in_if.sink                       in_ch,
  fbf_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fbf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fbf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [fbf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int IDX_BITS = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  typedef struct packed {
    logic                 act;
    logic                 found;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic [IDX_BITS-1:0]  idx;
  } scan_t;

  typedef struct packed {
    logic                 alloc;
    logic                 best_fit;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] req;
    logic                 upd;
    logic [IDX_BITS-1:0]  upd_idx;
  } ctl_t;

  logic [1:0]           state_r, state_nxt;
  logic                 go_r;
  logic                 fit_policy_r;
  logic                 alloc_r;
  logic [ADDR_BITS-1:0] base_r;
  logic [ADDR_BITS-1:0] req_r;
  logic                 best_fit_r;
  logic                 res_found_r;
  logic [IDX_BITS-1:0]  res_idx_r;
  logic [ADDR_BITS-1:0] res_start_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [ADDR_BITS-1:0] out_start_r;

  logic                 in_fire;
  logic                 done_fire;
  logic                 cfg_wr;
  scan_t                head;
  scan_t                chain [SEGMENTS];
  scan_t                last;
  ctl_t                 ctl;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == fbf_pkg::REG_FIT_POLICY);
  assign cfg_prdata = (cfg_paddr[2] == fbf_pkg::REG_FIT_POLICY) ?
                      {{(fbf_pkg::CFG_DW-1){1'b0}}, fit_policy_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= fbf_pkg::POLICY_FIRST;
    end else if (cfg_wr) begin
      fit_policy_r <= cfg_pwdata[0];
    end
  end

  // Handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign done_fire   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (last.act) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= in_fire;
    end
  end

  // Word held for the whole search
  always_ff @(posedge clk) begin
    if (in_fire) begin
      alloc_r    <= (in_ch.cmd == fbf_pkg::CMD_ALLOC);
      base_r     <= in_ch.region_start;
      req_r      <= in_ch.req_size;
      best_fit_r <= (fit_policy_r == fbf_pkg::POLICY_BEST);
    end
  end

  // Outcome of the search at the end of the chain
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && last.act) begin
      res_found_r <= last.found;
      res_idx_r   <= last.idx;
      res_start_r <= last.start;
    end
  end

  // Broadcast control to the cells
  always_comb begin
    ctl.alloc    = alloc_r;
    ctl.best_fit = best_fit_r;
    ctl.base     = base_r;
    ctl.req      = req_r;
    ctl.upd      = done_fire && res_found_r;
    ctl.upd_idx  = res_idx_r;
  end

  always_comb begin
    head       = '0;
    head.act   = go_r;
    head.found = 1'b0;
  end

  // Row of table cells
  for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
    scan_t cell_in;
    if (g == 0) begin : g_head
      assign cell_in = head;
    end else begin : g_link
      assign cell_in = chain[g-1];
    end
    fbf_cell #(
      .ADDR_BITS (ADDR_BITS),
      .IDX_BITS  (IDX_BITS),
      .IDX       (g),
      .scan_t    (scan_t),
      .ctl_t     (ctl_t)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .scan_in  (cell_in),
      .scan_out (chain[g])
    );
  end

  assign last = chain[SEGMENTS-1];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      if (res_found_r) begin
        out_status_r <= fbf_pkg::ST_OK;
      end else if (alloc_r) begin
        out_status_r <= fbf_pkg::ST_NOFIT;
      end else begin
        out_status_r <= fbf_pkg::ST_FULL;
      end
      out_start_r <= (res_found_r && alloc_r) ? res_start_r : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.alloc_start = out_start_r;

endmodule

// ----- hw/rtl/fbf_checker.sv -----
// Port-level checks for the allocator core, attached by bind.
// Depends on fbf_pkg and first_best_fit_allocator_core.
module fbf_checker #(
  parameter int ADDR_BITS = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [ADDR_BITS-1:0] out_alloc_start,
  input logic                 cfg_pready
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_alloc_start))
    else $error("result word changed while stalled");

  // One word in flight: acceptance closes the input
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // Only defined status codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == fbf_pkg::ST_OK) ||
    (out_status == fbf_pkg::ST_NOFIT) || (out_status == fbf_pkg::ST_FULL))
    else $error("undefined status code");

  // Failed words carry a zero start
  a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fbf_pkg::ST_OK) |-> (out_alloc_start == '0))
    else $error("nonzero start on a failed word");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind first_best_fit_allocator_core fbf_checker #(.ADDR_BITS(ADDR_BITS)) u_fbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_alloc_start (out_ch.alloc_start),
  .cfg_pready      (cfg_pready)
);

// ----- dv/alloc_sb_pkg.sv -----
// Scoreboard for the free-region allocator: a table model that predicts
// the status and start address of each word, and a queue of pending results.
// Depends on fbf_pkg.
package alloc_sb_pkg;

  localparam int SEGMENTS  = 16;
  localparam int ADDR_BITS = 16;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic [1:0] status;
    addr_t      alloc_start;
  } alloc_result_t;

  class alloc_scoreboard;
    addr_t         seg_start [SEGMENTS];
    addr_t         seg_size  [SEGMENTS];
    bit            seg_live  [SEGMENTS];
    logic          policy;
    alloc_result_t pending [$];
    int            errors;

    function new();
      foreach (seg_live[i]) begin
        seg_start[i] = '0;
        seg_size[i]  = '0;
        seg_live[i]  = 1'b0;
      end
      policy = fbf_pkg::POLICY_FIRST;
      errors = 0;
    endfunction

    function void set_policy(logic p);
      policy = p;
    endfunction

    // Best fit ranks by size first; both policies fall back to start address
    function bit beats(int cand, int best);
      if (policy == fbf_pkg::POLICY_BEST && seg_size[cand] != seg_size[best])
        return seg_size[cand] < seg_size[best];
      return seg_start[cand] < seg_start[best];
    endfunction

    // Apply an accepted word to the table and queue the result it must give
    function void note_word(logic cmd, addr_t start, addr_t size);
      alloc_result_t r;
      int            best;
      bit            found;
      r.status      = fbf_pkg::ST_OK;
      r.alloc_start = '0;
      best          = 0;
      found         = 1'b0;
      if (cmd == fbf_pkg::CMD_ADD) begin
        r.status = fbf_pkg::ST_FULL;
        for (int i = 0; i < SEGMENTS; i++) begin
          if (!seg_live[i]) begin
            seg_start[i] = start;
            seg_size[i]  = size;
            seg_live[i]  = 1'b1;
            r.status     = fbf_pkg::ST_OK;
            break;
          end
        end
      end else begin
        // lowest index wins on a full tie, so only strictly better replaces
        for (int i = 0; i < SEGMENTS; i++) begin
          if (seg_live[i] && seg_size[i] >= size && (!found || beats(i, best))) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = fbf_pkg::ST_NOFIT;
        end else begin
          r.alloc_start   = seg_start[best];
          seg_start[best] = seg_start[best] + size;  // wraps at ADDR_BITS
          seg_size[best]  = seg_size[best] - size;
          if (seg_size[best] == '0) seg_live[best] = 1'b0;
        end
      end
      pending = {pending, r};
    endfunction

    function void check_word(logic [1:0] status, addr_t alloc_start);
      alloc_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: status %0d alloc_start %h", status, alloc_start);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (alloc_start !== want.alloc_start) begin
        $error("alloc_start: expected %h, got %h", want.alloc_start, alloc_start);
        errors++;
      end
    endfunction

    // Size of some live region, so requests can hit an exact fit
    function addr_t pick_size();
      addr_t sizes [$];
      foreach (seg_live[i]) begin
        if (seg_live[i]) sizes = {sizes, seg_size[i]};
      end
      if (sizes.size() == 0) return addr_t'($urandom);
      return sizes[$urandom_range(0, sizes.size() - 1)];
    endfunction
  endclass

endpackage

// ----- dv/testbench.sv -----
// Top-level testbench for first_best_fit_allocator_core: directed and random
// add/allocate words under both fit policies with random idling on both sides.
// Depends on fbf_pkg, fbf_ifs, alloc_sb_pkg and the core RTL.
module testbench;

  localparam int SEGMENTS  = alloc_sb_pkg::SEGMENTS;
  localparam int ADDR_BITS = alloc_sb_pkg::ADDR_BITS;
  localparam int CFG_AW    = fbf_pkg::CFG_AW;
  localparam int CFG_DW    = fbf_pkg::CFG_DW;

  typedef alloc_sb_pkg::addr_t addr_t;

  localparam int LATENCY = SEGMENTS + 3;
  localparam logic [CFG_AW-1:0] FIT_POLICY_ADDR =
    CFG_AW'(4 * int'(fbf_pkg::REG_FIT_POLICY));

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  alloc_sb_pkg::alloc_scoreboard sb = new();

  fbf_in_if  #(.ADDR_BITS(ADDR_BITS)) in_ch ();
  fbf_out_if #(.ADDR_BITS(ADDR_BITS)) out_ch ();

  first_best_fit_allocator_core #(
    .SEGMENTS (SEGMENTS),
    .ADDR_BITS(ADDR_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Handshake monitor: results checked before the new word is noted
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.status, out_ch.alloc_start);
    if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.cmd, in_ch.region_start, in_ch.req_size);
  end

  // Result side: random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Present one word, hold until accepted, then maybe idle for a random while
  task automatic send_word(logic cmd, addr_t start, addr_t size);
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.region_start <= start;
    in_ch.req_size     <= size;
    do @(posedge clk); while (!in_ch.ready);
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // One APB transfer to the policy register; reads check bit 0
  task automatic cfg_access(bit wr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= FIT_POLICY_ADDR;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      sb.set_policy(data[0]);
    end else if (cfg_prdata[0] !== sb.policy) begin
      $error("fit_policy: expected %0d, got %0d", sb.policy, cfg_prdata[0]);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Change policy while idle; upper data bits are noise the block must ignore
  task automatic switch_policy(logic p);
    drain_results();
    cfg_access(1'b1, ($urandom() & ~32'h1) | CFG_DW'(p));
    cfg_access(1'b0, '0);
  endtask

  // Random mix of adds and allocations; add_pct steers fill versus drain
  task automatic run_phase(int words, int add_pct);
    addr_t size;
    for (int n = 0; n < words; n++) begin
      if ($urandom_range(1, 100) <= add_pct) begin
        case ($urandom_range(0, 7))
          0:       size = '0;
          1:       size = addr_t'($urandom);
          default: size = addr_t'($urandom_range(1, 512));
        endcase
        send_word(fbf_pkg::CMD_ADD, addr_t'($urandom), size);
      end else begin
        case ($urandom_range(0, 7))
          0:       size = '0;
          1, 2:    size = sb.pick_size();
          3:       size = addr_t'($urandom);
          default: size = addr_t'($urandom_range(1, 256));
        endcase
        send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), size);
      end
    end
  endtask

  initial begin
    int add_pcts   [6] = '{30, 70, 50, 65, 35, 50};
    int gap_pcts   [6] = '{15, 10, 0, 20, 12, 0};
    int stall_pcts [6] = '{6, 0, 8, 5, 10, 0};

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = fbf_pkg::CMD_ADD;
    in_ch.region_start = '0;
    in_ch.req_size     = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the policy register
    cfg_access(1'b0, '0);

    // Directed, first fit: empty table, zero-size region, equal sizes, wrap
    recv_stall_pct = 5;
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), '0);
    send_word(fbf_pkg::CMD_ADD, 16'hFFF0, 16'h0020);
    send_word(fbf_pkg::CMD_ADD, 16'h1000, 16'h0000);
    send_word(fbf_pkg::CMD_ADD, 16'h0100, 16'h0010);
    send_word(fbf_pkg::CMD_ADD, 16'h0200, 16'h0010);
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), 16'h0000);
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), 16'hFFFF);
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), 16'h0020);

    // Directed, best fit: exact fit, zero-size region taken, size tie to lowest start
    switch_policy(fbf_pkg::POLICY_BEST);
    send_word(fbf_pkg::CMD_ADD, 16'h0300, 16'h0008);
    send_word(fbf_pkg::CMD_ADD, 16'h0050, 16'h0010);
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), 16'h0008);
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), 16'h0000);
    send_word(fbf_pkg::CMD_ALLOC, addr_t'($urandom), 16'h0010);

    // Fill with identical maximal regions until the table reports full
    repeat (15) send_word(fbf_pkg::CMD_ADD, '1, '1);
    send_word(fbf_pkg::CMD_ALLOC, '0, '1);
    send_word(fbf_pkg::CMD_ALLOC, '1, '1);

    // Random phases, alternating policy; the last one runs without idling
    for (int phase = 0; phase < 6; phase++) begin
      switch_policy((phase % 2) ? fbf_pkg::POLICY_BEST : fbf_pkg::POLICY_FIRST);
      send_gap_pct   = gap_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      run_phase(140, add_pcts[phase]);
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
